// ===== rtl/core/asp_pkg.sv =====
// shared constants, types and the table function of the ancestry switch probability block
package asp_pkg;

    localparam int ASP_PROB_FRAC_BITS = 31;
    localparam int ASP_EXP_TABLE_BITS = 8;

    localparam logic [31:0] ASP_RATE_RESET = 32'd429497;

    localparam logic [63:0] ASP_ONE62    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ASP_LN2_Q64  = 64'hB172_17F7_D1CF_79AB;
    localparam logic [63:0] ASP_LOG2E_Q63 = 64'hB8AA_3B29_5C17_F0BB;

    // queue depth is a power of two so the pointers wrap on their own
    localparam int ASP_QUEUE_DEPTH = 4;
    localparam int ASP_QPTR_W      = $clog2(ASP_QUEUE_DEPTH);
    localparam int ASP_QCNT_W      = $clog2(ASP_QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        first_locus;
        logic        toggled;
        logic        last_locus;
        logic [31:0] gap_bp;
    } asp_entry_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } asp_mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] product;
    } asp_mul_rsp_t;

    // 2^-(k/2^tbl_bits) in q.62, truncating taylor series of exp(-k*ln2/2^tbl_bits)
    function automatic logic [63:0] asp_exp_tbl_entry(input int unsigned k,
                                                      input int unsigned tbl_bits);
        logic [127:0] prod;
        logic [63:0]  arg;
        logic [63:0]  term;
        logic [63:0]  sum;
        prod = 128'(k) * {64'b0, ASP_LN2_Q64};
        arg  = 64'(prod >> (2 + tbl_bits));
        term = ASP_ONE62;
        sum  = ASP_ONE62;
        for (int unsigned n = 1; n <= 30; n++) begin
            prod = {64'b0, term} * {64'b0, arg};
            term = 64'(prod >> 62) / 64'(n);
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

// ===== rtl/core/asp_if.sv =====
// valid/ready channel interfaces for loci in and probabilities out
interface asp_in_if;
    logic        valid;
    logic        ready;
    logic        ancestry_bit;
    logic [31:0] gap_bp;
    logic        last_locus;

    modport source (output valid, ancestry_bit, gap_bp, last_locus, input ready);
    modport sink   (input valid, ancestry_bit, gap_bp, last_locus, output ready);
endinterface

interface asp_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] probability;

    modport source (output valid, probability, input ready);
    modport sink   (input valid, probability, output ready);
endinterface

// ===== rtl/core/asp_front.sv =====
// front end: takes loci and classifies them as first, toggled and last
module asp_front import asp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    asp_in_if.sink       in_items,
    output logic         q_push,
    output asp_entry_t   q_entry,
    input  logic         q_full
);

    logic prev_bit_reg;
    logic prev_bit_next;
    logic mid_reg;
    logic mid_next;
    logic accept;

    assign in_items.ready = !q_full;
    assign accept         = in_items.valid && !q_full;
    assign q_push         = in_items.valid;

    always_comb
    begin
        q_entry.first_locus = !mid_reg;
        q_entry.toggled     = in_items.ancestry_bit ^ prev_bit_reg;
        q_entry.last_locus  = in_items.last_locus;
        q_entry.gap_bp      = in_items.gap_bp;
    end

    always_comb
    begin
        prev_bit_next = prev_bit_reg;
        mid_next      = mid_reg;
        if (accept)
        begin
            prev_bit_next = in_items.ancestry_bit;
            mid_next      = !in_items.last_locus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bit_reg <= 1'b0;
            mid_reg      <= 1'b0;
        end
        else
        begin
            prev_bit_reg <= prev_bit_next;
            mid_reg      <= mid_next;
        end
    end

endmodule

// ===== rtl/core/asp_queue.sv =====
// short fifo of classified loci between front and back
module asp_queue import asp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  asp_entry_t  push_entry,
    output logic        full,
    input  logic        pop,
    output logic        pop_valid,
    output asp_entry_t  pop_entry
);

    asp_entry_t              mem_reg [ASP_QUEUE_DEPTH];
    logic [ASP_QPTR_W-1:0]   wr_ptr_reg;
    logic [ASP_QPTR_W-1:0]   wr_ptr_next;
    logic [ASP_QPTR_W-1:0]   rd_ptr_reg;
    logic [ASP_QPTR_W-1:0]   rd_ptr_next;
    logic [ASP_QCNT_W-1:0]   count_reg;
    logic [ASP_QCNT_W-1:0]   count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (count_reg == ASP_QCNT_W'(ASP_QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/asp_mul.sv =====
// 64 by 64 multiplier, one registered 32 by 32 partial product a cycle
module asp_mul import asp_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  asp_mul_req_t  req,
    output asp_mul_rsp_t  rsp
);

    logic [63:0]  a_reg;
    logic [63:0]  a_next;
    logic [63:0]  b_reg;
    logic [63:0]  b_next;
    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic [63:0]  pp_reg;
    logic [63:0]  pp_next;
    logic [1:0]   sh_reg;
    logic [1:0]   sh_next;
    logic         pp_valid_reg;
    logic         pp_valid_next;
    logic [2:0]   cnt_reg;
    logic [2:0]   cnt_next;
    logic         busy_reg;
    logic         busy_next;
    logic         done_reg;
    logic         done_next;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_aligned;

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_aligned = {64'b0, pp_reg};
            2'd1:    pp_aligned = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_aligned = {pp_reg, 64'b0};
            default: pp_aligned = '0;
        endcase
    end

    always_comb
    begin
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        pp_next       = pp_reg;
        sh_next       = sh_reg;
        pp_valid_next = 1'b0;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[2])
            begin
                pp_next       = {32'b0, a_half} * {32'b0, b_half};
                sh_next       = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                pp_valid_next = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
            end
            if (pp_valid_reg)
            begin
                acc_next = acc_reg + pp_aligned;
            end
            if (cnt_reg[2] && pp_valid_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg        <= '0;
            b_reg        <= '0;
            acc_reg      <= '0;
            pp_reg       <= '0;
            sh_reg       <= '0;
            pp_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            a_reg        <= a_next;
            b_reg        <= b_next;
            acc_reg      <= acc_next;
            pp_reg       <= pp_next;
            sh_reg       <= sh_next;
            pp_valid_reg <= pp_valid_next;
            cnt_reg      <= cnt_next;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
        end
    end

endmodule

// ===== rtl/core/asp_back.sv =====
// back end: exp(-2*rate*gap), switch factor, running product and result register
module asp_back import asp_pkg::*; #(
    parameter int PROB_FRAC_BITS = ASP_PROB_FRAC_BITS,
    parameter int EXP_TABLE_BITS = ASP_EXP_TABLE_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata,
    input  logic          q_valid,
    input  asp_entry_t    q_entry,
    output logic          q_pop,
    output asp_mul_req_t  mul_req,
    input  asp_mul_rsp_t  mul_rsp,
    asp_out_if.source     out_items
);

    localparam int TBL_SIZE = 1 << EXP_TABLE_BITS;
    localparam int R_W      = 32 - EXP_TABLE_BITS;
    localparam int PROD_W   = PROB_FRAC_BITS + 1;
    localparam int F_SHIFT  = 62 - PROB_FRAC_BITS;
    localparam int OUT_SHR  = (PROB_FRAC_BITS >= 31) ? PROB_FRAC_BITS - 31 : 0;
    localparam int OUT_SHL  = (PROB_FRAC_BITS >= 31) ? 0 : 31 - PROB_FRAC_BITS;
    localparam logic [PROD_W-1:0] PROD_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};
    localparam logic [31:0] SHIFT_LIMIT = 32'd62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE_GAP,
        ST_LOG2,
        ST_RESID,
        ST_CORR,
        ST_FACTOR,
        ST_PROD,
        ST_FINISH
    } state_t;

    logic [63:0] tbl_rom [TBL_SIZE];

    for (genvar k = 0; k < TBL_SIZE; k++)
    begin : g_tbl
        localparam logic [63:0] ENTRY = asp_exp_tbl_entry(k, EXP_TABLE_BITS);
        assign tbl_rom[k] = ENTRY;
    end

    state_t              state_reg;
    state_t              state_next;
    logic [31:0]         rate_reg;
    logic [31:0]         rate_next;
    logic                toggled_reg;
    logic                toggled_next;
    logic                last_reg;
    logic                last_next;
    logic [5:0]          n_reg;
    logic [5:0]          n_next;
    logic [62:0]         base_reg;
    logic [62:0]         base_next;
    logic [62:0]         e_reg;
    logic [62:0]         e_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic                mul_start_reg;
    logic                mul_start_next;
    logic [63:0]         mul_a_reg;
    logic [63:0]         mul_a_next;
    logic [63:0]         mul_b_reg;
    logic [63:0]         mul_b_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [30:0]         out_prob_reg;
    logic [30:0]         out_prob_next;

    logic [63:0]         y;
    logic [62:0]         base_corr;
    logic [63:0]         factor;
    logic [63:0]         half;
    logic [63:0]         res;

    assign mul_req.start = mul_start_reg;
    assign mul_req.a     = mul_a_reg;
    assign mul_req.b     = mul_b_reg;

    assign out_items.valid       = out_valid_reg;
    assign out_items.probability = out_prob_reg;

    // y = 2*t*log2(e) in q.32, integer part is the shift, fraction indexes the table
    assign y         = mul_rsp.product[125:62];
    assign base_corr = base_reg - mul_rsp.product[124:62];

    always_comb
    begin
        if (toggled_reg)
        begin
            factor = (ASP_ONE62 - {1'b0, e_reg}) >> 1;
        end
        else
        begin
            factor = (ASP_ONE62 + {1'b0, e_reg}) >> 1;
        end
    end

    assign half = 64'(prod_reg) >> 1;
    assign res  = (half >> OUT_SHR) << OUT_SHL;

    always_comb
    begin
        state_next     = state_reg;
        rate_next      = rate_reg;
        toggled_next   = toggled_reg;
        last_next      = last_reg;
        n_next         = n_reg;
        base_next      = base_reg;
        e_next         = e_reg;
        prod_next      = prod_reg;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        out_valid_next = out_valid_reg && !out_items.ready;
        out_prob_next  = out_prob_reg;
        q_pop          = 1'b0;

        if (cfg_we)
        begin
            rate_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    toggled_next = q_entry.toggled;
                    last_next    = q_entry.last_locus;
                    if (q_entry.first_locus)
                    begin
                        prod_next  = PROD_ONE;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mul_start_next = 1'b1;
                        mul_a_next     = {32'b0, rate_reg};
                        mul_b_next     = {32'b0, q_entry.gap_bp};
                        state_next     = ST_RATE_GAP;
                    end
                end
            end
            ST_RATE_GAP:
            begin
                if (mul_rsp.done)
                begin
                    // rate*gap of 32.0 or more: exp term is zero
                    if (mul_rsp.product[63:37] != '0)
                    begin
                        e_next     = '0;
                        state_next = ST_FACTOR;
                    end
                    else
                    begin
                        mul_start_next = 1'b1;
                        mul_a_next     = {27'b0, mul_rsp.product[36:0]};
                        mul_b_next     = ASP_LOG2E_Q63;
                        state_next     = ST_LOG2;
                    end
                end
            end
            ST_LOG2:
            begin
                if (mul_rsp.done)
                begin
                    if (y[63:32] >= SHIFT_LIMIT)
                    begin
                        e_next     = '0;
                        state_next = ST_FACTOR;
                    end
                    else
                    begin
                        n_next         = y[37:32];
                        base_next      = tbl_rom[y[31 -: EXP_TABLE_BITS]][62:0];
                        mul_start_next = 1'b1;
                        mul_a_next     = 64'(y[R_W-1:0]);
                        mul_b_next     = ASP_LN2_Q64;
                        state_next     = ST_RESID;
                    end
                end
            end
            ST_RESID:
            begin
                if (mul_rsp.done)
                begin
                    // residual fraction times ln2, q.62
                    mul_start_next = 1'b1;
                    mul_a_next     = {1'b0, base_reg};
                    mul_b_next     = mul_rsp.product[97:34];
                    state_next     = ST_CORR;
                end
            end
            ST_CORR:
            begin
                if (mul_rsp.done)
                begin
                    e_next     = base_corr >> n_reg;
                    state_next = ST_FACTOR;
                end
            end
            ST_FACTOR:
            begin
                mul_start_next = 1'b1;
                mul_a_next     = 64'(prod_reg);
                mul_b_next     = factor >> F_SHIFT;
                state_next     = ST_PROD;
            end
            ST_PROD:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.product[PROB_FRAC_BITS +: PROD_W];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || out_items.ready)
                begin
                    out_valid_next = 1'b1;
                    out_prob_next  = res[30:0];
                    prod_next      = PROD_ONE;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= ASP_RATE_RESET;
            toggled_reg   <= 1'b0;
            last_reg      <= 1'b0;
            n_reg         <= '0;
            base_reg      <= '0;
            e_reg         <= '0;
            prod_reg      <= PROD_ONE;
            mul_start_reg <= 1'b0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_prob_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            toggled_reg   <= toggled_next;
            last_reg      <= last_next;
            n_reg         <= n_next;
            base_reg      <= base_next;
            e_reg         <= e_next;
            prod_reg      <= prod_next;
            mul_start_reg <= mul_start_next;
            mul_a_reg     <= mul_a_next;
            mul_b_reg     <= mul_b_next;
            out_valid_reg <= out_valid_next;
            out_prob_reg  <= out_prob_next;
        end
    end

endmodule

// ===== rtl/core/ancestry_switch_probability_top.sv =====
// top level of the ancestry switch probability block
//
// loci enter on in_items and the probability of each ancestry configuration leaves on
// out_items when its last locus has been worked through, as half the running product of
// the per-gap switch factors (p on an ancestry change, 1-p otherwise). the front takes a
// locus in a cycle into a four-deep queue while it has room; the back works through one
// locus at a time on a single 64x64 multiplier that forms one 32x32 partial product a
// cycle. a first locus needs no multiplication, a locus whose rate*gap reaches 32.0
// needs only rate*gap and product, one whose exponent shift reaches 62 also needs log2
// scaling, and any other locus takes rate*gap, log2 scaling, residual, table correction
// and product. a finished result waits in the output register while the next loci are
// worked on. recomb_rate is written through cfg_we/cfg_wdata and resets to about 1e-4.
module ancestry_switch_probability_top import asp_pkg::*; #(
    parameter int PROB_FRAC_BITS = ASP_PROB_FRAC_BITS,
    parameter int EXP_TABLE_BITS = ASP_EXP_TABLE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    asp_in_if.sink      in_items,
    asp_out_if.source   out_items
);

    logic          q_push;
    logic          q_full;
    asp_entry_t    q_push_entry;
    logic          q_pop;
    logic          q_valid;
    asp_entry_t    q_pop_entry;
    asp_mul_req_t  mul_req;
    asp_mul_rsp_t  mul_rsp;

    asp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_items (in_items),
        .q_push   (q_push),
        .q_entry  (q_push_entry),
        .q_full   (q_full)
    );

    asp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_pop_entry)
    );

    asp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    asp_back #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_entry   (q_pop_entry),
        .q_pop     (q_pop),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .out_items (out_items)
    );

endmodule
